>>> sv/gdma_pkg.sv
// ----------------------------------------------------------------------------
// gdma_pkg
// Types, codes and constant tables shared by the DMA channel engine modules.
// ----------------------------------------------------------------------------
package gdma_pkg;

    // Action codes of one input transaction
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;
    localparam logic [1:0] ACT_TRIGGER = 2'd3;

    // Register window
    localparam logic [15:0] WINDOW_LO = 16'h4300;
    localparam logic [15:0] WINDOW_HI = 16'h4380;

    // Register indexes within a channel
    localparam logic [3:0] REG_CTRL     = 4'd0;
    localparam logic [3:0] REG_BBASE    = 4'd1;
    localparam logic [3:0] REG_AOFF_LO  = 4'd2;
    localparam logic [3:0] REG_AOFF_HI  = 4'd3;
    localparam logic [3:0] REG_ABANK    = 4'd4;
    localparam logic [3:0] REG_COUNT_LO = 4'd5;
    localparam logic [3:0] REG_COUNT_HI = 4'd6;
    localparam logic [3:0] REG_IBANK    = 4'd7;
    localparam logic [3:0] REG_TAB_LO   = 4'd8;
    localparam logic [3:0] REG_TAB_HI   = 4'd9;
    localparam logic [3:0] REG_LINE     = 4'd10;

    // A address step modes, control bits 4:3
    localparam logic [1:0] STEP_INC = 2'd0;
    localparam logic [1:0] STEP_DEC = 2'd2;

    localparam logic [22:0] START_CYCLES = 23'd8;
    localparam logic [22:0] BYTE_CYCLES  = 23'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] reg_address;
        logic [7:0]  write_data;
        logic [7:0]  channel_mask;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_driven;
        logic        xfer_valid;
        logic [23:0] a_address;
        logic [7:0]  b_offset;
        logic        b_to_a;
        logic [2:0]  xfer_channel;
        logic        done_res;
        logic [22:0] cycles_used;
        logic        busy_res;
    } t_result;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic       hit;
        logic [2:0] channel;
        logic [3:0] reg_idx;
        logic [7:0] wdata;
        logic [7:0] mask;
    } t_cmd;

    // B offset pattern per mode (bits 2:0) and position
    function automatic logic [1:0] b_pattern(input logic [2:0] mode, input logic [1:0] pos);
        logic [1:0] off;
        off = 2'd0;
        unique case (mode)
            3'd1, 3'd5: off = {1'b0, pos[0]};
            3'd3, 3'd7: off = {1'b0, pos[1]};
            3'd4:       off = pos;
            default:    off = 2'd0;
        endcase
        return off;
    endfunction

    // Lowest set bit of a channel mask, zero when empty
    function automatic logic [2:0] lowest_channel(input logic [7:0] m);
        logic [2:0] c;
        c = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                c = 3'(i);
            end
        end
        return c;
    endfunction

endpackage

>>> sv/general_dma_channel_engine_unit.sv
// ----------------------------------------------------------------------------
// general_dma_channel_engine_unit
// Eight-channel byte DMA engine: register file, trigger and transfer issue.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one action per
// transaction: tick, register read, register write or trigger. Output channel
// (o_out_valid / i_out_ready / o_out_data) returns exactly one result per
// input transaction, in order.
// A front stage decodes the register address and pushes the command into a
// two-entry queue; the back stage executes it against the channel registers
// and loads the registered result stage.
// A result passes through a queue entry and then the registered result stage.
// The engine takes one transaction per cycle while the receiver does not stall;
// the back stage performs one register access or one byte step per command.
// When the receiver stalls, the result stage holds and the queue absorbs up
// to two more transactions before o_in_ready drops.
// Reset clears all channel registers, the pending mask, the sequencer state,
// the queue and the result stage.
// ----------------------------------------------------------------------------
module general_dma_channel_engine_unit #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gdma_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gdma_pkg::t_result o_out_data
);

    gdma_pkg::t_cmd front_cmd;
    gdma_pkg::t_cmd head_cmd;
    logic           head_valid;
    logic           pop;

    gdma_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .i_item (i_in_data),
        .o_cmd  (front_cmd)
    );

    gdma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_cmd   (front_cmd),
        .o_ready (o_in_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    gdma_back #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/gdma_front.sv
// ----------------------------------------------------------------------------
// gdma_front
// Decodes an incoming transaction: register window hit, channel, register.
// ----------------------------------------------------------------------------
module gdma_front #(
    parameter int NUM_CHANNELS = 8
) (
    input  gdma_pkg::t_item i_item,
    output gdma_pkg::t_cmd  o_cmd
);

    localparam logic [7:0] CH_LIMIT = 8'((1 << NUM_CHANNELS) - 1);

    logic [2:0] ch;
    logic [3:0] ri;
    logic       in_window;

    always_comb begin
        ch        = i_item.reg_address[6:4];
        ri        = i_item.reg_address[3:0];
        in_window = (i_item.reg_address >= gdma_pkg::WINDOW_LO) &&
                    (i_item.reg_address <  gdma_pkg::WINDOW_HI);

        o_cmd.action  = i_item.action;
        o_cmd.hit     = in_window && (32'(ch) < NUM_CHANNELS) &&
                        (ri <= gdma_pkg::REG_LINE);
        o_cmd.channel = ch;
        o_cmd.reg_idx = ri;
        o_cmd.wdata   = i_item.write_data;
        o_cmd.mask    = i_item.channel_mask & CH_LIMIT;
    end

endmodule

>>> sv/gdma_queue.sv
// ----------------------------------------------------------------------------
// gdma_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module gdma_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gdma_pkg::t_cmd i_cmd,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output gdma_pkg::t_cmd o_cmd
);

    gdma_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

>>> sv/gdma_back.sv
// ----------------------------------------------------------------------------
// gdma_back
// Channel register file, transfer sequencer and registered result stage.
// ----------------------------------------------------------------------------
module gdma_back #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  gdma_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gdma_pkg::t_result o_out_data
);

    localparam int         CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [7:0] CH_LIMIT = 8'((1 << NUM_CHANNELS) - 1);

    logic [7:0]  r_ctrl  [NUM_CHANNELS];
    logic [7:0]  r_bbase [NUM_CHANNELS];
    logic [15:0] r_aoff  [NUM_CHANNELS];
    logic [7:0]  r_abank [NUM_CHANNELS];
    logic [15:0] r_count [NUM_CHANNELS];
    logic [7:0]  r_ibank [NUM_CHANNELS];
    logic [7:0]  r_tlo   [NUM_CHANNELS];
    logic [7:0]  r_thi   [NUM_CHANNELS];
    logic [7:0]  r_line  [NUM_CHANNELS];

    logic [7:0]  r_pending;
    logic [2:0]  r_cur;
    logic [1:0]  r_step;
    logic        r_active;
    logic [22:0] r_cycles;

    logic [7:0]  n_pending;
    logic [2:0]  n_cur;
    logic [1:0]  n_step;
    logic        n_active;
    logic [22:0] n_cycles;

    logic              r_out_valid;
    gdma_pkg::t_result r_out_data;
    gdma_pkg::t_result n_res;

    logic [CH_W-1:0] idx;
    logic [7:0]      ctl;
    logic [15:0]     aoff;
    logic [15:0]     n_aoff;
    logic [15:0]     n_cnt;
    logic [7:0]      rd_byte;
    logic [7:0]      rem_mask;
    logic            is_tick;
    logic            is_write;

    assign o_pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        // ticks address the running channel, register accesses the decoded one
        idx      = (i_cmd.action == gdma_pkg::ACT_TICK) ? r_cur[CH_W-1:0]
                                                        : i_cmd.channel[CH_W-1:0];
        ctl      = r_ctrl[idx];
        aoff     = r_aoff[idx];
        is_tick  = (i_cmd.action == gdma_pkg::ACT_TICK) && r_active;
        is_write = (i_cmd.action == gdma_pkg::ACT_WRITE) && i_cmd.hit;

        unique case (ctl[4:3])
            gdma_pkg::STEP_INC: n_aoff = aoff + 16'd1;
            gdma_pkg::STEP_DEC: n_aoff = aoff - 16'd1;
            default:            n_aoff = aoff;
        endcase
        n_cnt    = r_count[idx] - 16'd1;
        rem_mask = r_pending & ~(8'd1 << r_cur) & CH_LIMIT;

        unique case (i_cmd.reg_idx)
            gdma_pkg::REG_CTRL:     rd_byte = r_ctrl[idx];
            gdma_pkg::REG_BBASE:    rd_byte = r_bbase[idx];
            gdma_pkg::REG_AOFF_LO:  rd_byte = r_aoff[idx][7:0];
            gdma_pkg::REG_AOFF_HI:  rd_byte = r_aoff[idx][15:8];
            gdma_pkg::REG_ABANK:    rd_byte = r_abank[idx];
            gdma_pkg::REG_COUNT_LO: rd_byte = r_count[idx][7:0];
            gdma_pkg::REG_COUNT_HI: rd_byte = r_count[idx][15:8];
            gdma_pkg::REG_IBANK:    rd_byte = r_ibank[idx];
            gdma_pkg::REG_TAB_LO:   rd_byte = r_tlo[idx];
            gdma_pkg::REG_TAB_HI:   rd_byte = r_thi[idx];
            gdma_pkg::REG_LINE:     rd_byte = r_line[idx];
            default:                rd_byte = 8'd0;
        endcase

        n_pending = r_pending;
        n_cur     = r_cur;
        n_step    = r_step;
        n_active  = r_active;
        n_cycles  = r_cycles;
        n_res     = '0;

        unique case (i_cmd.action)
            gdma_pkg::ACT_READ: begin
                if (i_cmd.hit) begin
                    n_res.read_data   = rd_byte;
                    n_res.read_driven = 1'b1;
                end
            end
            gdma_pkg::ACT_TRIGGER: begin
                if (!r_active) begin
                    n_cycles = gdma_pkg::START_CYCLES;
                    if (i_cmd.mask == 8'd0) begin
                        n_res.done_res    = 1'b1;
                        n_res.cycles_used = gdma_pkg::START_CYCLES;
                    end else begin
                        n_pending = i_cmd.mask;
                        n_cur     = gdma_pkg::lowest_channel(i_cmd.mask);
                        n_step    = 2'd0;
                        n_active  = 1'b1;
                    end
                end
            end
            gdma_pkg::ACT_TICK: begin
                if (r_active) begin
                    n_res.xfer_valid   = 1'b1;
                    n_res.a_address    = {r_abank[idx], aoff};
                    n_res.b_offset     = r_bbase[idx] +
                                         {6'd0, gdma_pkg::b_pattern(ctl[2:0], r_step)};
                    n_res.b_to_a       = ctl[7];
                    n_res.xfer_channel = r_cur;
                    n_step             = r_step + 2'd1;
                    n_cycles           = r_cycles + gdma_pkg::BYTE_CYCLES;
                    if (n_cnt == 16'd0) begin
                        n_pending = rem_mask;
                        if (rem_mask == 8'd0) begin
                            n_active          = 1'b0;
                            n_res.done_res    = 1'b1;
                            n_res.cycles_used = n_cycles;
                        end else begin
                            n_cur  = gdma_pkg::lowest_channel(rem_mask);
                            n_step = 2'd0;
                        end
                    end
                end
            end
            default: ;
        endcase
        n_res.busy_res = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 8'd0;
            r_cur       <= 3'd0;
            r_step      <= 2'd0;
            r_active    <= 1'b0;
            r_cycles    <= 23'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pending   <= n_pending;
                r_cur       <= n_cur;
                r_step      <= n_step;
                r_active    <= n_active;
                r_cycles    <= n_cycles;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_res;
        end
    end

    // Channel register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_ctrl[c]  <= 8'd0;
                r_bbase[c] <= 8'd0;
                r_aoff[c]  <= 16'd0;
                r_abank[c] <= 8'd0;
                r_count[c] <= 16'd0;
                r_ibank[c] <= 8'd0;
                r_tlo[c]   <= 8'd0;
                r_thi[c]   <= 8'd0;
                r_line[c]  <= 8'd0;
            end
        end else if (o_pop) begin
            if (is_tick) begin
                r_aoff[idx]  <= n_aoff;
                r_count[idx] <= n_cnt;
            end else if (is_write) begin
                unique case (i_cmd.reg_idx)
                    gdma_pkg::REG_CTRL:     r_ctrl[idx]        <= i_cmd.wdata;
                    gdma_pkg::REG_BBASE:    r_bbase[idx]       <= i_cmd.wdata;
                    gdma_pkg::REG_AOFF_LO:  r_aoff[idx][7:0]   <= i_cmd.wdata;
                    gdma_pkg::REG_AOFF_HI:  r_aoff[idx][15:8]  <= i_cmd.wdata;
                    gdma_pkg::REG_ABANK:    r_abank[idx]       <= i_cmd.wdata;
                    gdma_pkg::REG_COUNT_LO: r_count[idx][7:0]  <= i_cmd.wdata;
                    gdma_pkg::REG_COUNT_HI: r_count[idx][15:8] <= i_cmd.wdata;
                    gdma_pkg::REG_IBANK:    r_ibank[idx]       <= i_cmd.wdata;
                    gdma_pkg::REG_TAB_LO:   r_tlo[idx]         <= i_cmd.wdata;
                    gdma_pkg::REG_TAB_HI:   r_thi[idx]         <= i_cmd.wdata;
                    gdma_pkg::REG_LINE:     r_line[idx]        <= i_cmd.wdata;
                    default: ;
                endcase
            end
        end
    end

    a_active_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_pending != 8'd0))
        else $error("active with empty pending mask");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_pending == 8'd0))
        else $error("pending channels left while idle");

    a_cur_is_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pending[r_cur])
        else $error("current channel not in pending mask");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.done_res) |-> !r_out_data.busy_res)
        else $error("done reported while still busy");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-channel DMA engine. A scoreboard class
// keeps its own copy of the channel registers and the sequencer and predicts
// the result of every accepted transaction. Stimulus is a short directed
// pass over the open-bus and corner cases, then random program/trigger/tick
// sequences with register traffic mixed in. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_CH        = 8;
    localparam int N_ITEMS     = 1050;
    localparam int HOLD_CYCLES = 80;
    localparam int WDOG_LIMIT  = 2000;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts one result per accepted transaction
    // ------------------------------------------------------------------------
    class dma_result_scoreboard;
        logic [7:0]        ctl_q    [N_CH];
        logic [7:0]        bbase_q  [N_CH];
        logic [15:0]       aoff_q   [N_CH];
        logic [7:0]        bank_q   [N_CH];
        logic [15:0]       count_q  [N_CH];
        logic [7:0]        ibank_q  [N_CH];
        logic [7:0]        tab_lo_q [N_CH];
        logic [7:0]        tab_hi_q [N_CH];
        logic [7:0]        line_q   [N_CH];
        logic [7:0]        run_mask;
        logic [2:0]        run_ch;
        logic [1:0]        pat_pos;
        bit                running;
        logic [22:0]       cyc_total;
        gdma_pkg::t_result pending_results [$];
        int                errors;
        int                n_checked;
        int                n_xfers;
        int                n_done;

        function new();
            for (int c = 0; c < N_CH; c++) begin
                ctl_q[c]    = '0;
                bbase_q[c]  = '0;
                aoff_q[c]   = '0;
                bank_q[c]   = '0;
                count_q[c]  = '0;
                ibank_q[c]  = '0;
                tab_lo_q[c] = '0;
                tab_hi_q[c] = '0;
                line_q[c]   = '0;
            end
            run_mask  = '0;
            run_ch    = '0;
            pat_pos   = '0;
            running   = 0;
            cyc_total = '0;
            errors    = 0;
            n_checked = 0;
            n_xfers   = 0;
            n_done    = 0;
        endfunction

        function bit busy();
            return running;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // B offset of a mode at a pattern position; patterns packed pos3..pos0
        function logic [1:0] mode_offset(input logic [2:0] mode, input logic [1:0] pos);
            logic [7:0] pat;
            case (mode)
                3'd1, 3'd5: pat = 8'b01_00_01_00;
                3'd3, 3'd7: pat = 8'b01_01_00_00;
                3'd4:       pat = 8'b11_10_01_00;
                default:    pat = 8'b00_00_00_00;
            endcase
            return pat[2*pos +: 2];
        endfunction

        function logic [2:0] first_channel(input logic [7:0] m);
            logic [2:0] c;
            c = '0;
            for (int i = 7; i >= 0; i--) begin
                if (m[i]) begin
                    c = 3'(i);
                end
            end
            return c;
        endfunction

        function logic [7:0] read_reg(input int c, input logic [3:0] idx);
            case (idx)
                gdma_pkg::REG_CTRL:     return ctl_q[c];
                gdma_pkg::REG_BBASE:    return bbase_q[c];
                gdma_pkg::REG_AOFF_LO:  return aoff_q[c][7:0];
                gdma_pkg::REG_AOFF_HI:  return aoff_q[c][15:8];
                gdma_pkg::REG_ABANK:    return bank_q[c];
                gdma_pkg::REG_COUNT_LO: return count_q[c][7:0];
                gdma_pkg::REG_COUNT_HI: return count_q[c][15:8];
                gdma_pkg::REG_IBANK:    return ibank_q[c];
                gdma_pkg::REG_TAB_LO:   return tab_lo_q[c];
                gdma_pkg::REG_TAB_HI:   return tab_hi_q[c];
                default:                return line_q[c];
            endcase
        endfunction

        function void write_reg(input int c, input logic [3:0] idx, input logic [7:0] d);
            case (idx)
                gdma_pkg::REG_CTRL:     ctl_q[c] = d;
                gdma_pkg::REG_BBASE:    bbase_q[c] = d;
                gdma_pkg::REG_AOFF_LO:  aoff_q[c][7:0] = d;
                gdma_pkg::REG_AOFF_HI:  aoff_q[c][15:8] = d;
                gdma_pkg::REG_ABANK:    bank_q[c] = d;
                gdma_pkg::REG_COUNT_LO: count_q[c][7:0] = d;
                gdma_pkg::REG_COUNT_HI: count_q[c][15:8] = d;
                gdma_pkg::REG_IBANK:    ibank_q[c] = d;
                gdma_pkg::REG_TAB_LO:   tab_lo_q[c] = d;
                gdma_pkg::REG_TAB_HI:   tab_hi_q[c] = d;
                default:                line_q[c] = d;
            endcase
        endfunction

        function void take_command(input gdma_pkg::t_item it);
            gdma_pkg::t_result r;
            bit                hit;
            int                c;
            logic [3:0]        idx;
            logic [7:0]        m;
            logic [7:0]        ctl;
            logic [7:0]        lim;
            r   = '0;
            lim = 8'((9'd1 << N_CH) - 1);
            c   = int'(it.reg_address[6:4]);
            idx = it.reg_address[3:0];
            hit = (it.reg_address >= gdma_pkg::WINDOW_LO) &&
                  (it.reg_address < gdma_pkg::WINDOW_HI) &&
                  (idx <= gdma_pkg::REG_LINE) && (c < N_CH);
            case (it.action)
                gdma_pkg::ACT_READ: begin
                    if (hit) begin
                        r.read_data   = read_reg(c, idx);
                        r.read_driven = 1'b1;
                    end
                end
                gdma_pkg::ACT_WRITE: begin
                    if (hit) begin
                        write_reg(c, idx, it.write_data);
                    end
                end
                gdma_pkg::ACT_TRIGGER: begin
                    if (!running) begin
                        m = it.channel_mask & lim;
                        cyc_total = gdma_pkg::START_CYCLES;
                        if (m == '0) begin
                            r.done_res    = 1'b1;
                            r.cycles_used = cyc_total;
                        end else begin
                            run_mask = m;
                            run_ch   = first_channel(m);
                            pat_pos  = '0;
                            running  = 1;
                        end
                    end
                end
                default: begin
                    if (running) begin
                        c   = int'(run_ch);
                        ctl = ctl_q[c];
                        r.xfer_valid   = 1'b1;
                        r.a_address    = {bank_q[c], aoff_q[c]};
                        r.b_offset     = bbase_q[c] + {6'd0, mode_offset(ctl[2:0], pat_pos)};
                        r.b_to_a       = ctl[7];
                        r.xfer_channel = run_ch;
                        if (ctl[4:3] == gdma_pkg::STEP_INC) begin
                            aoff_q[c] = aoff_q[c] + 16'd1;
                        end else if (ctl[4:3] == gdma_pkg::STEP_DEC) begin
                            aoff_q[c] = aoff_q[c] - 16'd1;
                        end
                        count_q[c] = count_q[c] - 16'd1;
                        pat_pos    = pat_pos + 2'd1;
                        cyc_total  = cyc_total + gdma_pkg::BYTE_CYCLES;
                        if (count_q[c] == '0) begin
                            run_mask[c] = 1'b0;
                            run_mask    = run_mask & lim;
                            if (run_mask == '0) begin
                                running       = 0;
                                r.done_res    = 1'b1;
                                r.cycles_used = cyc_total;
                            end else begin
                                run_ch  = first_channel(run_mask);
                                pat_pos = '0;
                            end
                        end
                    end
                end
            endcase
            r.busy_res = running;
            pending_results.push_back(r);
        endfunction

        function void compare_field(input string nm, input logic [31:0] w,
                                    input logic [31:0] g);
            if (w !== g) begin
                $display("%0t: mismatch on %s: expected %h, actual %h", $time, nm, w, g);
                errors++;
            end
        endfunction

        function void check_result(input gdma_pkg::t_result got);
            gdma_pkg::t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no transaction pending: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (want.xfer_valid) n_xfers++;
            if (want.done_res) n_done++;
            compare_field("read_data",    want.read_data,    got.read_data);
            compare_field("read_driven",  want.read_driven,  got.read_driven);
            compare_field("xfer_valid",   want.xfer_valid,   got.xfer_valid);
            compare_field("a_address",    want.a_address,    got.a_address);
            compare_field("b_offset",     want.b_offset,     got.b_offset);
            compare_field("b_to_a",       want.b_to_a,       got.b_to_a);
            compare_field("xfer_channel", want.xfer_channel, got.xfer_channel);
            compare_field("done_res",     want.done_res,     got.done_res);
            compare_field("cycles_used",  want.cycles_used,  got.cycles_used);
            compare_field("busy_res",     want.busy_res,     got.busy_res);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic              i_clk     = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    gdma_pkg::t_item   in_data   = '0;
    logic              out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    gdma_pkg::t_result o_out_data;

    bit          tx_free     = 0;
    bit          rx_free     = 0;
    bit          rx_hold_req = 0;
    int unsigned n_items     = 0;
    int unsigned n_seq       = 0;
    int unsigned idle_cycles = 0;

    dma_result_scoreboard sb;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    general_dma_channel_engine_unit #(
        .NUM_CHANNELS(N_CH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // Result side: check every accepted result
    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : rx_proc
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                stall_left  = HOLD_CYCLES;
            end else if (stall_left == 0 && !rx_free && $urandom_range(0, 3) == 0) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles without any transaction on either side
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (tx_free) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] reg_addr(input int ch, input logic [3:0] idx);
        return gdma_pkg::WINDOW_LO + 16'(ch * 16) + 16'(idx);
    endfunction

    task automatic send(input logic [1:0] act, input logic [15:0] addr,
                        input logic [7:0] data, input logic [7:0] mask);
        gdma_pkg::t_item it;
        int              gap;
        it.action       = act;
        it.reg_address  = addr;
        it.write_data   = data;
        it.channel_mask = mask;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_command(it);
        n_items++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Unused fields of a transaction carry random values
    task automatic tick();
        send(gdma_pkg::ACT_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic reg_rd(input logic [15:0] addr);
        send(gdma_pkg::ACT_READ, addr, 8'($urandom), 8'($urandom));
    endtask

    task automatic reg_wr(input logic [15:0] addr, input logic [7:0] d);
        send(gdma_pkg::ACT_WRITE, addr, d, 8'($urandom));
    endtask

    task automatic trigger(input logic [7:0] mask);
        send(gdma_pkg::ACT_TRIGGER, 16'($urandom), 8'($urandom), mask);
    endtask

    task automatic program_channel(input int ch);
        logic [15:0] cnt;
        logic [15:0] aoff;
        cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                          : 16'($urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0) begin
            aoff = $urandom_range(0, 1) ? 16'hFFFE : 16'h0001;
        end else begin
            aoff = 16'($urandom);
        end
        reg_wr(reg_addr(ch, gdma_pkg::REG_CTRL), 8'($urandom));
        reg_wr(reg_addr(ch, gdma_pkg::REG_BBASE), 8'($urandom));
        reg_wr(reg_addr(ch, gdma_pkg::REG_AOFF_LO), aoff[7:0]);
        reg_wr(reg_addr(ch, gdma_pkg::REG_AOFF_HI), aoff[15:8]);
        reg_wr(reg_addr(ch, gdma_pkg::REG_ABANK), 8'($urandom));
        reg_wr(reg_addr(ch, gdma_pkg::REG_COUNT_LO), cnt[7:0]);
        reg_wr(reg_addr(ch, gdma_pkg::REG_COUNT_HI), cnt[15:8]);
        if ($urandom_range(0, 2) == 0) begin
            reg_wr(reg_addr(ch, gdma_pkg::REG_IBANK), 8'($urandom));
            reg_wr(reg_addr(ch, gdma_pkg::REG_TAB_LO), 8'($urandom));
            reg_wr(reg_addr(ch, gdma_pkg::REG_TAB_HI), 8'($urandom));
            reg_wr(reg_addr(ch, gdma_pkg::REG_LINE), 8'($urandom));
        end
    endtask

    // Program the masked channels, trigger, then tick to completion with
    // register traffic and ignored triggers mixed in
    task automatic run_sequence();
        logic [7:0] mask;
        logic [3:0] idx;
        int         sel;
        if ($urandom_range(0, 3) != 0) begin
            mask = 8'd1 << $urandom_range(0, 7);
            if ($urandom_range(0, 1)) mask = mask | (8'd1 << $urandom_range(0, 7));
        end else begin
            mask = 8'($urandom_range(1, 255));
        end
        for (int c = 0; c < N_CH; c++) begin
            if (mask[c]) program_channel(c);
        end
        trigger(mask);
        while (sb.busy()) begin
            sel = $urandom_range(0, 99);
            idx = 4'($urandom_range(0, 10));
            if (sel < 80) begin
                tick();
            end else if (sel < 88) begin
                reg_rd(reg_addr($urandom_range(0, 7), idx));
            end else if (sel < 93) begin
                // keep counts untouched so the run stays short
                if (idx == gdma_pkg::REG_COUNT_LO || idx == gdma_pkg::REG_COUNT_HI) begin
                    idx = gdma_pkg::REG_LINE;
                end
                reg_wr(reg_addr($urandom_range(0, 7), idx), 8'($urandom));
            end else if (sel < 96) begin
                trigger(8'($urandom));
            end else begin
                reg_rd(16'($urandom));
            end
        end
    endtask

    // Idle-time noise; an idle trigger gets an empty mask
    task automatic send_noise();
        logic [1:0]  act;
        logic [15:0] addr;
        act  = 2'($urandom);
        addr = $urandom_range(0, 1) ? 16'($urandom)
                                    : gdma_pkg::WINDOW_LO + 16'($urandom_range(0, 127));
        if (act == gdma_pkg::ACT_TRIGGER) begin
            trigger(8'd0);
        end else begin
            send(act, addr, 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_directed();
        reg_rd(reg_addr(0, gdma_pkg::REG_CTRL));
        reg_rd(gdma_pkg::WINDOW_LO - 16'd1);
        reg_rd(gdma_pkg::WINDOW_HI);
        reg_rd(16'h433F);                       // unused slot
        reg_wr(16'h430B, 8'hFF);                // unused slot, dropped
        reg_wr(16'hFFFF, 8'hFF);                // outside window, dropped
        tick();                                 // idle tick
        trigger(8'h00);                         // empty mask
        // channel 7: decrement from offset 0, count of zero
        reg_wr(reg_addr(7, gdma_pkg::REG_CTRL), 8'h94);
        reg_wr(reg_addr(7, gdma_pkg::REG_BBASE), 8'hFF);
        reg_wr(reg_addr(7, gdma_pkg::REG_AOFF_LO), 8'h00);
        reg_wr(reg_addr(7, gdma_pkg::REG_AOFF_HI), 8'h00);
        reg_wr(reg_addr(7, gdma_pkg::REG_ABANK), 8'hFF);
        reg_wr(reg_addr(7, gdma_pkg::REG_COUNT_LO), 8'h00);
        reg_wr(reg_addr(7, gdma_pkg::REG_COUNT_HI), 8'h00);
        trigger(8'h80);
        repeat (3) tick();
        trigger(8'hFF);                         // ignored while busy
        reg_rd(reg_addr(7, gdma_pkg::REG_COUNT_LO));
        // shorten the run while it is going
        reg_wr(reg_addr(7, gdma_pkg::REG_COUNT_LO), 8'h02);
        reg_wr(reg_addr(7, gdma_pkg::REG_COUNT_HI), 8'h00);
        repeat (2) tick();
        reg_rd(reg_addr(7, gdma_pkg::REG_AOFF_LO));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        while (n_items < N_ITEMS) begin
            tx_free = (n_seq % 7 == 6);
            rx_free = (n_seq % 5 == 4);
            if (n_seq == 4) begin
                // long receiver hold-off while the sender keeps offering
                tx_free     = 1;
                rx_hold_req = 1;
                repeat (12) reg_rd(reg_addr($urandom_range(0, 7), 4'($urandom_range(0, 10))));
                tx_free = 0;
            end
            run_sequence();
            repeat ($urandom_range(0, 4)) send_noise();
            n_seq++;
        end
        in_valid <= 1'b0;
        rx_free = 1;

        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d transactions in %0d programmed runs: %0d byte transfers,",
                 n_items, n_seq, sb.n_xfers);
        $display("%0d completed triggers, %0d results checked, %0d mismatches.",
                 sb.n_done, sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> general_dma_channel_engine_unit.f
sv/gdma_pkg.sv
sv/gdma_front.sv
sv/gdma_queue.sv
sv/gdma_back.sv
sv/general_dma_channel_engine_unit.sv
verif/tb.sv
